### hdl/bb33_pkg.sv
// Shared types, constants and the divide-by-nine helper for the 3x3 box blur.
`default_nettype none

package bb33_pkg;

  localparam int PIX_W      = 32;
  localparam int LANES      = 4;
  localparam int COORD_W    = 10;
  localparam int OUT_DATA_W = 56;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;
  localparam int LANE_SUM_W = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_W = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_H = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_W = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_H = 3'd5;

  localparam logic [12:0] DIV9_RECIP = 13'd7282;

  typedef logic [PIX_W-1:0]   pixel_t;
  typedef logic [2*PIX_W-1:0] line_pair_t;

  // floor(s / 9) for s up to 9 * 255
  function automatic logic [7:0] div9(input logic [LANE_SUM_W-1:0] s);
    logic [24:0] p;
    p = 25'(s) * 25'(DIV9_RECIP);
    return p[23:16];
  endfunction

endpackage

`default_nettype wire

### hdl/box_blur_3x3_rgba.sv
// Top level of the 3x3 box blur over a raster stream of 32-bit pixels.
//
// Input stream: s_tdata carries one pixel, s_tuser is 1 for a pad tick that stands
// for a position beyond the frame. A frame is canvas_width * canvas_height pixels
// followed by canvas_width + 1 pad ticks that flush the last row.
// Output stream: one transaction per centre inside the clipped region, carrying the
// blurred pixel and its canvas column and row; m_tlast marks the region's last pixel.
// Configuration: cfg_index selects canvas_width, canvas_height, region_x, region_y,
// region_w, region_h (0 to 5); any of these writes restarts the frame. Write only
// while no transaction is in flight.
// The transaction that completes a window is held in the input register, and the
// result register loads from it when that stage advances. Throughput: one pixel per
// cycle while the output is not stalled; the line store is read at acceptance
// and written as the input register advances, so a read and a write share a cycle.
// Reset clears the counters and both pipeline stages and loads the default
// configuration. When a result waits and m_tready is low, the result register holds
// and the input stage stalls behind it; s_tready falls only while both are full.
`default_nettype none

module box_blur_3x3_rgba
  import bb33_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [PIX_W-1:0]      s_tdata,   // [31:0] pixel
  input  wire logic                  s_tuser,   // [0] func
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [OUT_DATA_W-1:0]      m_tdata,   // [31:0] out_pixel, [41:32] out_x,
                                                // [51:42] out_y, [55:52] zero
  output logic                       m_tlast,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 2);
  localparam int AW = $clog2(MAX_WIDTH);

  logic [10:0] canvas_width, canvas_height, region_w, region_h;
  logic [9:0]  region_x, region_y;
  logic [11:0] x_end, y_end;
  logic [31:0] w32, h32, xe32, ye32;
  logic [CW-1:0] w;
  logic [RW-1:0] h;

  logic [CW-1:0] col, col_next;
  logic [RW-1:0] row, row_next;

  logic          accept, advance;
  logic          s1_valid;
  pixel_t        s1_val;
  logic [CW-1:0] s1_col;
  logic [RW-1:0] s1_row;
  line_pair_t    rd_data;

  pixel_t wcol1 [3];
  pixel_t wcol2 [3];
  pixel_t cur   [3];

  logic          wrap, cy_ok, left_ok, right_ok, top_ok, emit, is_last;
  logic [CW-1:0] cx;
  logic [RW-1:0] cy;
  pixel_t        nb [9];
  logic [LANE_SUM_W-1:0] lane_sum;
  pixel_t        blurred;

  pixel_t           out_pixel;
  logic [COORD_W-1:0] out_x, out_y;

  assign cfg_ready = 1'b1;

  // canvas size clamped to the supported range, region ends clipped to the canvas
  always_comb begin
    w32 = 32'(canvas_width);
    h32 = 32'(canvas_height);
    if (w32 == 32'd0) begin
      w32 = 32'd1;
    end else if (w32 > 32'(MAX_WIDTH)) begin
      w32 = 32'(MAX_WIDTH);
    end
    if (h32 == 32'd0) begin
      h32 = 32'd1;
    end else if (h32 > 32'(MAX_HEIGHT)) begin
      h32 = 32'(MAX_HEIGHT);
    end
    w = CW'(w32);
    h = RW'(h32);
    xe32 = 32'(region_x) + 32'(region_w);
    ye32 = 32'(region_y) + 32'(region_h);
    if (xe32 > w32) begin
      xe32 = w32;
    end
    if (ye32 > h32) begin
      ye32 = h32;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_width  <= 11'd1024;
      canvas_height <= 11'd1024;
      region_x      <= 10'd0;
      region_y      <= 10'd0;
      region_w      <= 11'd1024;
      region_h      <= 11'd1024;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_CANVAS_W: canvas_width  <= cfg_data;
        CFG_CANVAS_H: canvas_height <= cfg_data;
        CFG_REGION_X: region_x      <= cfg_data[9:0];
        CFG_REGION_Y: region_y      <= cfg_data[9:0];
        CFG_REGION_W: region_w      <= cfg_data;
        CFG_REGION_H: region_h      <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    x_end <= xe32[11:0];
    y_end <= ye32[11:0];
  end

  assign advance  = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || advance;
  assign accept   = s_tvalid && s_tready;

  // stream position of the next transaction
  always_comb begin
    col_next = col;
    row_next = row;
    if (32'(row) >= h32 + 32'd1) begin
      col_next = '0;
      row_next = '0;
    end else if (32'(col) + 32'd1 >= w32) begin
      col_next = '0;
      row_next = row + RW'(1);
    end else begin
      col_next = col + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (cfg_valid && cfg_ready && (cfg_index <= CFG_REGION_H)) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      col <= col_next;
      row <= row_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_val <= (!s_tuser && (row < h)) ? s_tdata : '0;
      s1_col <= col;
      s1_row <= row;
    end
  end

  bb33_line_store #(
    .DEPTH(MAX_WIDTH)
  ) u_line_store (
    .clk    (clk),
    .rd_en  (accept),
    .rd_addr(col[AW-1:0]),
    .rd_data(rd_data),
    .wr_en  (advance),
    .wr_addr(s1_col[AW-1:0]),
    .wr_data({rd_data[PIX_W-1:0], s1_val})
  );

  assign cur[0] = rd_data[2*PIX_W-1:PIX_W];
  assign cur[1] = rd_data[PIX_W-1:0];
  assign cur[2] = s1_val;

  always_ff @(posedge clk) begin
    if (advance) begin
      wcol2 <= wcol1;
      wcol1 <= cur;
    end
  end

  // centre position, neighbour masks and region tests
  always_comb begin
    wrap     = (s1_col == '0);
    cy_ok    = wrap ? (s1_row >= RW'(2)) : (s1_row >= RW'(1));
    cy       = wrap ? (s1_row - RW'(2)) : (s1_row - RW'(1));
    cx       = wrap ? (w - CW'(1)) : (s1_col - CW'(1));
    left_ok  = (cx != '0);
    right_ok = !wrap;
    top_ok   = (cy != '0);
    emit     = cy_ok &&
               (32'(cx) >= 32'(region_x)) && (32'(cx) < 32'(x_end)) &&
               (32'(cy) >= 32'(region_y)) && (32'(cy) < 32'(y_end));
    is_last  = (32'(cx) + 32'd1 == 32'(x_end)) && (32'(cy) + 32'd1 == 32'(y_end));
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      nb[3*r]     = (left_ok  && (top_ok || r != 0)) ? wcol2[r] : '0;
      nb[3*r + 1] = (top_ok || r != 0) ? wcol1[r] : '0;
      nb[3*r + 2] = (right_ok && (top_ok || r != 0)) ? cur[r] : '0;
    end
    blurred = '0;
    for (int k = 0; k < LANES; k++) begin
      lane_sum = '0;
      for (int n = 0; n < 9; n++) begin
        lane_sum = lane_sum + LANE_SUM_W'(nb[n][8*k +: 8]);
      end
      blurred[8*k +: 8] = div9(lane_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= emit;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_pixel <= blurred;
      out_x     <= COORD_W'(cx);
      out_y     <= COORD_W'(cy);
      m_tlast   <= is_last;
    end
  end

  assign m_tdata = {4'd0, out_y, out_x, out_pixel};

endmodule

`default_nettype wire

### hdl/bb33_line_store.sv
// Two-row line store: one word per column, registered read with write forwarding.
`default_nettype none

module bb33_line_store
  import bb33_pkg::*;
#(
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output line_pair_t         rd_data,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire line_pair_t    wr_data
);

  line_pair_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= (wr_en && (wr_addr == rd_addr)) ? wr_data : mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### hdl/bb33_checker.sv
// Port-level checks for the 3x3 box blur, bound to the top level.
`default_nettype none

module bb33_checker
  import bb33_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  s_tvalid,
  input wire logic                  s_tready,
  input wire logic [PIX_W-1:0]      s_tdata,
  input wire logic                  s_tuser,
  input wire logic                  m_tvalid,
  input wire logic                  m_tready,
  input wire logic [OUT_DATA_W-1:0] m_tdata,
  input wire logic                  m_tlast,
  input wire logic                  cfg_valid,
  input wire logic                  cfg_ready,
  input wire logic [CFG_IDX_W-1:0]  cfg_index,
  input wire logic [CFG_DATA_W-1:0] cfg_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output transaction changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_ready_when_out_free: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output register");

  a_ready_when_taken: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready |-> s_tready)
    else $error("input stalled while output is drained");

endmodule

bind box_blur_3x3_rgba bb33_checker u_bb33_checker (.*);

`default_nettype wire

### tb/sv/box_blur_3x3_rgba_chk.sv
// Checker for the 3x3 box blur: predicts blurred pixels from the stream and compares.
`default_nettype none

module box_blur_3x3_rgba_chk
  import bb33_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  input  wire logic                  s_tready,
  input  wire logic [PIX_W-1:0]      s_tdata,   // [31:0] pixel
  input  wire logic                  s_tuser,   // [0] func
  input  wire logic                  m_tvalid,
  input  wire logic                  m_tready,
  input  wire logic [OUT_DATA_W-1:0] m_tdata,   // [31:0] out_pixel, [41:32] out_x,
                                                // [51:42] out_y, [55:52] zero
  input  wire logic                  m_tlast,
  input  wire logic                  cfg_valid,
  input  wire logic                  cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  done,
  output int                         fails,
  output int                         pending,
  output int                         checked
);

  localparam int RING_DEPTH   = 2 * MAX_WIDTH + 3;
  localparam int LANE_DIVISOR = 9;

  typedef struct packed {
    pixel_t             pix;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               lst;
  } blur_t;

  pixel_t      recent_px [RING_DEPTH];
  blur_t       blur_due [$];
  logic [10:0] canvas_w, canvas_h, region_w, region_h;
  logic [9:0]  region_x, region_y;
  int unsigned col_at, row_at;
  logic        closed;

  initial begin
    fails   = 0;
    pending = 0;
    checked = 0;
    closed  = 1'b0;
  end

  function automatic int unsigned fit_dim(input logic [10:0] v, input int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    fails++;
    $display("mismatch %s: got %0h, want %0h (result %0d)", what, got, want, checked);
  endtask

  task automatic blur_step(input logic is_pad, input pixel_t pix);
    int unsigned w, h, pos, xe, ye, np;
    int          cx, cy, nx, ny;
    int unsigned acc [LANES];
    pixel_t      v;
    blur_t       e;
    w   = fit_dim(canvas_w, MAX_WIDTH);
    h   = fit_dim(canvas_h, MAX_HEIGHT);
    pos = row_at * w + col_at;
    recent_px[pos % RING_DEPTH] = (!is_pad && pos < w * h) ? pix : '0;
    if (col_at >= 1) begin
      cx = int'(col_at) - 1;
      cy = int'(row_at) - 1;
    end else begin
      cx = int'(w) - 1;
      cy = int'(row_at) - 2;
    end
    xe = region_x + region_w;
    if (xe > w) xe = w;
    ye = region_y + region_h;
    if (ye > h) ye = h;
    if (cy >= 0 && cy < int'(h) && cx >= int'(region_x) && cx < int'(xe) &&
        cy >= int'(region_y) && cy < int'(ye)) begin
      foreach (acc[k]) acc[k] = 0;
      for (int dy = -1; dy <= 1; dy++) begin
        for (int dx = -1; dx <= 1; dx++) begin
          nx = cx + dx;
          ny = cy + dy;
          if (nx >= 0 && nx < int'(w) && ny >= 0 && ny < int'(h)) begin
            np = unsigned'(ny) * w + unsigned'(nx);
            v  = recent_px[np % RING_DEPTH];
            for (int k = 0; k < LANES; k++) acc[k] += v[8*k +: 8];
          end
        end
      end
      for (int k = 0; k < LANES; k++) e.pix[8*k +: 8] = 8'(acc[k] / LANE_DIVISOR);
      e.x   = COORD_W'(cx);
      e.y   = COORD_W'(cy);
      e.lst = (cx == int'(xe) - 1) && (cy == int'(ye) - 1);
      blur_due.push_back(e);
    end
    if (row_at >= h + 1) begin
      row_at = 0;
      col_at = 0;
    end else begin
      col_at++;
      if (col_at >= w) begin
        col_at = 0;
        row_at++;
      end
    end
  endtask

  always @(posedge clk) begin
    blur_t e;
    if (rst) begin
      canvas_w = 11'd1024;
      canvas_h = 11'd1024;
      region_x = '0;
      region_y = '0;
      region_w = 11'd1024;
      region_h = 11'd1024;
      col_at   = 0;
      row_at   = 0;
      foreach (recent_px[i]) recent_px[i] = '0;
      blur_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_CANVAS_W: canvas_w = cfg_data;
          CFG_CANVAS_H: canvas_h = cfg_data;
          CFG_REGION_X: region_x = cfg_data[9:0];
          CFG_REGION_Y: region_y = cfg_data[9:0];
          CFG_REGION_W: region_w = cfg_data;
          CFG_REGION_H: region_h = cfg_data;
          default: ;
        endcase
        if (cfg_index <= CFG_REGION_H) begin
          col_at = 0;
          row_at = 0;
        end
      end
      if (m_tvalid && m_tready) begin
        if (blur_due.size() == 0) begin
          report_mismatch("unexpected result", m_tdata[PIX_W-1:0], 0);
        end else begin
          e = blur_due.pop_front();
          if (m_tdata[31:0] !== e.pix) report_mismatch("out_pixel", m_tdata[31:0], e.pix);
          if (m_tdata[41:32] !== e.x) report_mismatch("out_x", m_tdata[41:32], e.x);
          if (m_tdata[51:42] !== e.y) report_mismatch("out_y", m_tdata[51:42], e.y);
          if (m_tlast !== e.lst) report_mismatch("last", m_tlast, e.lst);
        end
        checked++;
      end
      if (s_tvalid && s_tready) blur_step(s_tuser, s_tdata);
      if (done && !closed) begin
        closed = 1'b1;
        if (blur_due.size() != 0) report_mismatch("results never seen", blur_due.size(), 0);
      end
    end
    pending = blur_due.size();
  end

endmodule

`default_nettype wire

### tb/sv/tb_box_blur_3x3_rgba.sv
// Testbench top for the 3x3 box blur: clock, reset, stimulus and verdict.
`default_nettype none

module tb_box_blur_3x3_rgba;
  import bb33_pkg::*;

  localparam int MAX_DIM         = 1024;
  localparam int STALL_LIMIT     = 3000;
  localparam int ITEMS_PER_PHASE = 180;

  localparam logic FUNC_PIXEL = 1'b0;
  localparam logic FUNC_PAD   = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_7 = 3'd7;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [PIX_W-1:0]      s_tdata   = '0;
  logic                  s_tuser   = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  run_done  = 1'b0;

  int mismatches, pending, checked;
  int tx_idle_pct = 15;
  int rx_idle_pct = 50;
  int items_sent  = 0;
  int settings    = 0;
  int cur_w       = MAX_DIM;
  int cur_h       = MAX_DIM;
  int idle_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  box_blur_3x3_rgba #(.MAX_WIDTH(MAX_DIM), .MAX_HEIGHT(MAX_DIM)) u_top (
    .clk, .rst,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tlast,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  box_blur_3x3_rgba_chk #(.MAX_WIDTH(MAX_DIM), .MAX_HEIGHT(MAX_DIM)) u_chk (
    .clk, .rst,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tlast,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .done(run_done), .fails(mismatches), .pending, .checked
  );

  always @(negedge clk) m_tready <= ($urandom_range(99, 0) >= rx_idle_pct);

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic send(input logic func, input pixel_t pix);
    while ($urandom_range(99, 0) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= pix;
    s_tuser  <= func;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(val);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // drain every predicted result, then allow the pipeline to empty
  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_frame(input int w, input int h, input int x, input int y,
                           input int rw, input int rh);
    settle();
    if ($urandom_range(7, 0) == 0)
      write_reg($urandom_range(1, 0) ? CFG_UNUSED_6 : CFG_UNUSED_7, $urandom_range(2047, 0));
    write_reg(CFG_CANVAS_W, w);
    write_reg(CFG_CANVAS_H, h);
    write_reg(CFG_REGION_X, x);
    write_reg(CFG_REGION_Y, y);
    write_reg(CFG_REGION_W, rw);
    write_reg(CFG_REGION_H, rh);
    cur_w = (w == 0) ? 1 : (w > MAX_DIM) ? MAX_DIM : w;
    cur_h = (h == 0) ? 1 : (h > MAX_DIM) ? MAX_DIM : h;
    settings++;
  endtask

  function automatic pixel_t pick_pixel(input int fill);
    case (fill)
      0: return $urandom;
      1: return '0;
      2: return '1;
      default: begin
        case ($urandom_range(2, 0))
          0: return '0;
          1: return '1;
          default: return $urandom;
        endcase
      end
    endcase
  endfunction

  // 0 < cut < frame length stops the frame early; flip_pct swaps pixel and pad marks at random
  task automatic run_frame(input int cut, input int flip_pct, input int fill);
    int   total;
    logic func;
    total = cur_w * cur_h + cur_w + 1;
    if (cut > 0 && cut < total) total = cut;
    for (int p = 0; p < total; p++) begin
      func = (p >= cur_w * cur_h) ? FUNC_PAD : FUNC_PIXEL;
      if ($urandom_range(99, 0) < flip_pct) func = ~func;
      send(func, pick_pixel(fill));
    end
  endtask

  initial begin
    int goal, w, h, reps, r, total;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    write_reg(CFG_UNUSED_6, 0);
    set_frame(3, 3, 0, 0, 1024, 1024);
    send(FUNC_PIXEL, 32'hFFFF_FFFF);
    send(FUNC_PIXEL, 32'h0000_0000);
    send(FUNC_PIXEL, 32'h80FF_0001);
    send(FUNC_PAD,   32'hFFFF_FFFF);
    send(FUNC_PIXEL, 32'hFFFF_FFFF);
    send(FUNC_PIXEL, 32'h1234_5678);
    settle();
    write_reg(CFG_UNUSED_7, 2047);
    repeat (3) send(FUNC_PIXEL, 32'hFFFF_FFFF);
    send(FUNC_PIXEL, 32'hFFFF_FFFF);
    repeat (3) send(FUNC_PAD, $urandom);

    set_frame(1, 1, 0, 0, 1, 1);
    run_frame(0, 0, 2);
    set_frame(2, 2, 0, 0, 0, 2);
    run_frame(0, 0, 0);
    set_frame(4, 3, 2, 1, 2047, 2047);
    run_frame(0, 0, 3);
    set_frame(5, 2, 1023, 1023, 1, 1);
    run_frame(0, 0, 0);
    set_frame(4, 4, 1, 1, 2, 2);
    run_frame(9, 0, 0);
    set_frame(4, 4, 0, 0, 4, 4);
    run_frame(0, 0, 2);

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          tx_idle_pct = 15;
          rx_idle_pct = 50;
        end
        1: begin
          tx_idle_pct = 50;
          rx_idle_pct = 15;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
          set_frame(2047, 1, 0, 0, 1024, 1024);
          run_frame(1040, 0, 0);
          set_frame(0, 2047, 0, 0, 1024, 1024);
          run_frame(40, 0, 0);
        end
      endcase
      goal = items_sent + ITEMS_PER_PHASE;
      while (items_sent < goal) begin
        w = ($urandom_range(9, 0) == 0) ? 0 :
            $urandom_range(($urandom_range(3, 0) == 0) ? 40 : 10, 1);
        h = ($urandom_range(9, 0) == 0) ? 0 : $urandom_range(6, 1);
        if ($urandom_range(9, 0) == 0)
          set_frame(w, h, $urandom_range(1023, 0), $urandom_range(1023, 0),
                    $urandom_range(2047, 0), $urandom_range(2047, 0));
        else
          set_frame(w, h, $urandom_range(w + 1, 0), $urandom_range(h + 1, 0),
                    $urandom_range(w + 2, 0), $urandom_range(h + 2, 0));
        reps = $urandom_range(2, 1);
        r = 0;
        while (r < reps) begin
          total = cur_w * cur_h + cur_w + 1;
          if ($urandom_range(9, 0) == 0) begin
            run_frame($urandom_range(total - 1, 1), 0, $urandom_range(3, 0));
            r = reps;
          end else begin
            run_frame(0, ($urandom_range(4, 0) == 0) ? 8 : 0, $urandom_range(3, 0));
            r++;
          end
        end
      end
    end

    settle();
    repeat (20) @(negedge clk);
    run_done <= 1'b1;
    @(negedge clk);
    @(negedge clk);
    $display("run covered %0d stream items over %0d canvas and region settings,",
             items_sent, settings);
    $display("with %0d blurred pixels compared against the prediction", checked);
    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

`default_nettype wire
